FILE: hdl/barometric_sensor_compensation_core_assert.svh
// Assertion macros used by the compensation core checker.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bsc_pkg.sv
// Types, constants and helper functions of the barometric compensation core.
`default_nettype none
package bsc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_OSS  = 2'd0,
    REG_CAL1 = 2'd1,
    REG_CAL2 = 2'd2,
    REG_CAL3 = 2'd3
  } cfg_reg_e;

  // Compensation constants.
  localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
  localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;
  localparam logic signed [31:0] B7_SCALE   = 32'sd50000;
  localparam logic signed [31:0] P_COEF_SQ  = 32'sd3038;
  localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
  localparam logic signed [31:0] P_COEF_OFS = 32'sd3791;
  localparam logic signed [31:0] T_ROUND    = 32'sd8;
  localparam logic signed [31:0] T_MAX      = 32'sd32767;
  localparam logic signed [31:0] T_MIN      = -32'sd32768;

  // Decoded calibration coefficients.
  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
  } calib_t;

  // Handoff from the temperature path to the pressure path.
  typedef struct packed {
    logic signed [15:0] t;
    logic signed [31:0] b6;
    logic        [23:0] up;
    logic               err;
  } temp_res_t;

  // Final result.
  typedef struct packed {
    logic signed [15:0] t;
    logic signed [31:0] p;
    logic               err;
  } res_t;

  // Low 32 bits of a 32 by 32 product; identical for signed and unsigned.
  function automatic logic signed [31:0] mul_lo(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] f;
    f = a * b;
    return $signed(f[31:0]);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bsc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module bsc_div_pipe #(
  parameter int unsigned NumW  = 32,
  parameter int unsigned DenW  = 32,
  parameter int unsigned SideW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [NumW-1:0]  num_i,
  input  wire logic [DenW-1:0]  den_i,
  input  wire logic [SideW-1:0] side_i,
  output logic                  valid_o,
  output logic [NumW-1:0]       quo_o,
  output logic [SideW-1:0]      side_o
);

  logic              vld_s  [0:NumW];
  logic [NumW-1:0]   num_s  [0:NumW];
  logic [DenW-1:0]   den_s  [0:NumW];
  logic [DenW-1:0]   rem_s  [0:NumW];
  logic [NumW-1:0]   quo_s  [0:NumW];
  logic [SideW-1:0]  side_s [0:NumW];

  // Stage zero is the input itself.
  assign vld_s[0]  = valid_i;
  assign num_s[0]  = num_i;
  assign den_s[0]  = den_i;
  assign rem_s[0]  = '0;
  assign quo_s[0]  = '0;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;
    logic [NumW-1:0] quo_d;

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
      trial = {rem_s[k], num_s[k][NumW-1-k]};
      diff  = trial - {1'b0, den_s[k]};
      ge    = (trial >= {1'b0, den_s[k]});
      quo_d = quo_s[k];
      quo_d[NumW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_s[k+1]  <= num_s[k];
        den_s[k+1]  <= den_s[k];
        rem_s[k+1]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        quo_s[k+1]  <= quo_d;
        side_s[k+1] <= side_s[k];
      end
    end
  end

  assign valid_o = vld_s[NumW];
  assign quo_o   = quo_s[NumW];
  assign side_o  = side_s[NumW];

endmodule
`default_nettype wire

FILE: hdl/bsc_temp.sv
// Temperature path: B5 through a pipelined divider, then T and B6.
`default_nettype none
module bsc_temp
  import bsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [15:0] ut_i,
  input  wire logic [23:0] up_raw_i,
  input  wire logic [1:0]  oss_i,
  input  wire calib_t      cal_i,
  output logic             valid_o,
  output temp_res_t        res_o
);

  localparam int unsigned DivNumW  = 27;
  localparam int unsigned DivDenW  = 32;
  localparam int unsigned DivSideW = 32 + 24 + 2;

  // Stage 1: raw pressure alignment and (UT - AC6) * AC5.
  logic               v1_q;
  logic signed [31:0] prod1_q;
  logic [23:0]        up1_q;
  logic signed [16:0] diff1;
  logic signed [33:0] prod1;

  always_comb begin
    diff1 = $signed({1'b0, ut_i}) - $signed({1'b0, cal_i.ac6});
    prod1 = diff1 * $signed({1'b0, cal_i.ac5});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= $signed(prod1[31:0]);
      up1_q   <= up_raw_i >> (4'd8 - {2'b00, oss_i});
    end
  end

  // Stage 2: X1 and the divisor X1 + MD.
  logic               v2_q;
  logic signed [31:0] x1_2_q;
  logic signed [31:0] den2_q;
  logic [23:0]        up2_q;
  logic signed [31:0] x1_2;

  assign x1_2 = prod1_q >>> 15;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_2_q <= x1_2;
      den2_q <= x1_2 + 32'(cal_i.md);
      up2_q  <= up1_q;
    end
  end

  // Stage 3: magnitudes and quotient sign for the divider.
  logic               v3_q;
  logic signed [31:0] x1_3_q;
  logic [31:0]        dmag3_q;
  logic               neg3_q;
  logic               dz3_q;
  logic [23:0]        up3_q;
  logic [15:0]        mc_mag;

  assign mc_mag = cal_i.mc[15] ? 16'(-cal_i.mc) : 16'(cal_i.mc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_3_q  <= x1_2_q;
      dmag3_q <= den2_q[31] ? 32'(-den2_q) : 32'(den2_q);
      neg3_q  <= cal_i.mc[15] ^ den2_q[31];
      dz3_q   <= (den2_q == '0);
      up3_q   <= up2_q;
    end
  end

  // MC * 2048 / (X1 + MD) on magnitudes.
  logic                div_v;
  logic [DivNumW-1:0]  div_q;
  logic [DivSideW-1:0] div_side;

  bsc_div_pipe #(
    .NumW  (DivNumW),
    .DenW  (DivDenW),
    .SideW (DivSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v3_q),
    .num_i   ({mc_mag, 11'b0}),
    .den_i   (dmag3_q),
    .side_i  ({x1_3_q, up3_q, neg3_q, dz3_q}),
    .valid_o (div_v),
    .quo_o   (div_q),
    .side_o  (div_side)
  );

  // Stage 4: signed X2 and B5.
  logic               v4_q;
  logic signed [31:0] b5_4_q;
  logic [23:0]        up4_q;
  logic               dz4_q;
  logic signed [31:0] q32;
  logic signed [31:0] x2_4;

  always_comb begin
    q32  = $signed({5'b0, div_q});
    x2_4 = div_side[1] ? -q32 : q32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b5_4_q <= $signed(div_side[DivSideW-1 -: 32]) + x2_4;
      up4_q  <= div_side[25:2];
      dz4_q  <= div_side[0];
    end
  end

  // Stage 5: saturated temperature and B6.
  logic               v5_q;
  temp_res_t          res5_q;
  logic signed [31:0] t_full;
  logic signed [15:0] t_sat;

  always_comb begin
    t_full = (b5_4_q + T_ROUND) >>> 4;
    priority if (t_full > T_MAX) begin
      t_sat = 16'(T_MAX);
    end else if (t_full < T_MIN) begin
      t_sat = 16'(T_MIN);
    end else begin
      t_sat = t_full[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res5_q.t   <= t_sat;
      res5_q.b6  <= b5_4_q - B6_OFFSET;
      res5_q.up  <= up4_q;
      res5_q.err <= dz4_q;
    end
  end

  assign valid_o = v5_q;
  assign res_o   = res5_q;

endmodule
`default_nettype wire

FILE: hdl/bsc_press.sv
// Pressure path: B3, B4, B7, pipelined division and the final correction.
`default_nettype none
module bsc_press
  import bsc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      en_i,
  input  wire logic      valid_i,
  input  wire temp_res_t tres_i,
  input  wire logic [1:0] oss_i,
  input  wire calib_t    cal_i,
  output logic           valid_o,
  output res_t           res_o
);

  localparam int unsigned DivNumW  = 32;
  localparam int unsigned DivDenW  = 17;
  localparam int unsigned DivSideW = 16 + 2;

  // Valid bits of the stages before and after the divider.
  logic [11:1] v_q;
  logic        div_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q[7:1]  <= {v_q[6:1], valid_i};
      v_q[11:8] <= {v_q[10:8], div_v};
    end
  end

  // Stage 1: products with B6.
  logic signed [31:0] sqm1_q, mac2_1_q, mac3_1_q;
  temp_res_t          tr1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqm1_q   <= mul_lo(tres_i.b6, tres_i.b6);
      mac2_1_q <= mul_lo(32'(cal_i.ac2), tres_i.b6);
      mac3_1_q <= mul_lo(32'(cal_i.ac3), tres_i.b6);
      tr1_q    <= tres_i;
    end
  end

  // Stage 2: scaling shifts.
  logic signed [31:0] sq2_q, x2a2_q, x1c2_q;
  temp_res_t          tr2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq2_q  <= sqm1_q >>> 12;
      x2a2_q <= mac2_1_q >>> 11;
      x1c2_q <= mac3_1_q >>> 13;
      tr2_q  <= tr1_q;
    end
  end

  // Stage 3: products with the squared term.
  logic signed [31:0] mb2_3_q, mb1_3_q, x2a3_q, x1c3_q;
  temp_res_t          tr3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mb2_3_q <= mul_lo(32'(cal_i.b2), sq2_q);
      mb1_3_q <= mul_lo(32'(cal_i.b1), sq2_q);
      x2a3_q  <= x2a2_q;
      x1c3_q  <= x1c2_q;
      tr3_q   <= tr2_q;
    end
  end

  // Stage 4: shifted sum for B3 and the B4 multiplicand.
  logic signed [31:0] s4_q, tmp4_q;
  temp_res_t          tr4_q;
  logic signed [31:0] s_sum, x3b;

  always_comb begin
    s_sum = (32'(cal_i.ac1) <<< 2) + ((mb2_3_q >>> 11) + x2a3_q);
    x3b   = (x1c3_q + (mb1_3_q >>> 16) + 32'sd2) >>> 2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_q   <= s_sum << oss_i;
      tmp4_q <= x3b + B4_OFFSET;
      tr4_q  <= tr3_q;
    end
  end

  // Stage 5: B3 rounded toward zero, and AC4 product.
  logic signed [31:0] b3_5_q, m4_5_q;
  temp_res_t          tr5_q;
  logic signed [31:0] v5;

  always_comb begin
    v5 = s4_q + 32'sd2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b3_5_q <= (v5 + (v5[31] ? 32'sd3 : 32'sd0)) >>> 2;
      m4_5_q <= mul_lo($signed({16'b0, cal_i.ac4}), tmp4_q);
      tr5_q  <= tr4_q;
    end
  end

  // Stage 6: B7 and B4.
  logic [31:0]  b7_6_q;
  logic [16:0]  b4_6_q;
  temp_res_t    tr6_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b7_6_q <= 32'(mul_lo($signed({8'b0, tr5_q.up}) - b3_5_q, B7_SCALE >>> oss_i));
      b4_6_q <= m4_5_q[31:15];
      tr6_q  <= tr5_q;
    end
  end

  // Stage 7: dividend selection and zero-divisor check.
  logic [31:0]  num7_q;
  logic [16:0]  b4_7_q;
  logic         hi7_q;
  logic         err7_q;
  logic [15:0]  t7_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num7_q <= b7_6_q[31] ? b7_6_q : {b7_6_q[30:0], 1'b0};
      b4_7_q <= b4_6_q;
      hi7_q  <= b7_6_q[31];
      err7_q <= tr6_q.err | (b4_6_q == '0);
      t7_q   <= tr6_q.t;
    end
  end

  // Unsigned B7 / B4 division.
  logic [DivNumW-1:0]  div_q;
  logic [DivSideW-1:0] div_side;

  bsc_div_pipe #(
    .NumW  (DivNumW),
    .DenW  (DivDenW),
    .SideW (DivSideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v_q[7]),
    .num_i   (num7_q),
    .den_i   (b4_7_q),
    .side_i  ({t7_q, hi7_q, err7_q}),
    .valid_o (div_v),
    .quo_o   (div_q),
    .side_o  (div_side)
  );

  // Stage 8: raw pressure.
  logic signed [31:0] p8_q;
  logic [15:0]        t8_q;
  logic               err8_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p8_q   <= $signed(div_side[1] ? {div_q[30:0], 1'b0} : div_q);
      t8_q   <= div_side[17:2];
      err8_q <= div_side[0];
    end
  end

  // Stage 9: first correction products.
  logic signed [31:0] p9_q, aa9_q, lin9_q;
  logic [15:0]        t9_q;
  logic               err9_q;
  logic signed [31:0] a8;

  assign a8 = p8_q >>> 8;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p9_q   <= p8_q;
      aa9_q  <= mul_lo(a8, a8);
      lin9_q <= mul_lo(P_COEF_LIN, p8_q);
      t9_q   <= t8_q;
      err9_q <= err8_q;
    end
  end

  // Stage 10: square term coefficient.
  logic signed [31:0] p10_q, sq10_q, x2_10_q;
  logic [15:0]        t10_q;
  logic               err10_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p10_q   <= p9_q;
      sq10_q  <= mul_lo(aa9_q, P_COEF_SQ);
      x2_10_q <= lin9_q >>> 16;
      t10_q   <= t9_q;
      err10_q <= err9_q;
    end
  end

  // Stage 11: final pressure, with error masking.
  res_t               res11_q;
  logic signed [31:0] p_fin;

  assign p_fin = p10_q + ((((sq10_q >>> 16) + x2_10_q) + P_COEF_OFS) >>> 4);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res11_q.t   <= err10_q ? '0 : $signed(t10_q);
      res11_q.p   <= err10_q ? '0 : p_fin;
      res11_q.err <= err10_q;
    end
  end

  assign valid_o = v_q[11];
  assign res_o   = res11_q;

endmodule
`default_nettype wire

FILE: hdl/barometric_sensor_compensation_core.sv
// Top level of the barometric compensation core: configuration and stream ports.
//
//  Channel  Direction  Handshake                 Content
//  s_axis   in         s_axis_tvalid/tready      raw temperature, raw pressure bytes
//  m_axis   out        m_axis_tvalid/tready      temperature, pressure; tuser = error
//  cfg      in         cfg_valid_i/cfg_ready_o   register index and write data
//
// One transaction per cycle is accepted while m_axis does not stall; the path runs through the
// 27-stage and 32-stage pipelined dividers and the multiplier stages around them.
// Reset clears the valid bits and the configuration registers to zero.
// A stall on m_axis freezes the whole pipeline; s_axis_tready falls in the same cycle.
`default_nettype none
module barometric_sensor_compensation_core
  import bsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // [15:0] raw_temperature, [39:16] raw_pressure_bytes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // [15:0] temperature_tenths, [47:16] pressure_pascal
  output logic             m_axis_tuser,  // [0] divide_error
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  // Configuration registers.
  logic [1:0]  oss_q;
  logic [63:0] cal1_q, cal2_q;
  logic [31:0] cal3_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q  <= '0;
      cal1_q <= '0;
      cal2_q <= '0;
      cal3_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_OSS:  oss_q  <= cfg_data_i[1:0];
        REG_CAL1: cal1_q <= cfg_data_i;
        REG_CAL2: cal2_q <= cfg_data_i;
        REG_CAL3: cal3_q <= cfg_data_i[31:0];
        default:  oss_q  <= oss_q;
      endcase
    end
  end

  // Coefficient decode.
  calib_t cal;

  always_comb begin
    cal.ac1 = $signed(cal1_q[63:48]);
    cal.ac2 = $signed(cal1_q[47:32]);
    cal.ac3 = $signed(cal1_q[31:16]);
    cal.ac4 = cal1_q[15:0];
    cal.ac5 = cal2_q[63:48];
    cal.ac6 = cal2_q[47:32];
    cal.b1  = $signed(cal2_q[31:16]);
    cal.b2  = $signed(cal2_q[15:0]);
    cal.mc  = $signed(cal3_q[31:16]);
    cal.md  = $signed(cal3_q[15:0]);
  end

  // Global pipeline advance: the output register is empty or being drained.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic      tv;
  temp_res_t tres;
  res_t      res;

  bsc_temp u_temp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .ut_i     (s_axis_tdata[15:0]),
    .up_raw_i (s_axis_tdata[39:16]),
    .oss_i    (oss_q),
    .cal_i    (cal),
    .valid_o  (tv),
    .res_o    (tres)
  );

  bsc_press u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv),
    .tres_i  (tres),
    .oss_i   (oss_q),
    .cal_i   (cal),
    .valid_o (m_axis_tvalid),
    .res_o   (res)
  );

  assign m_axis_tdata = {res.p, res.t};
  assign m_axis_tuser = res.err;

endmodule
`default_nettype wire

FILE: hdl/bsc_checker.sv
// Port-level checker of the compensation core, bound to the top level.
`default_nettype none
`include "barometric_sensor_compensation_core_assert.svh"
module bsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // A stalled result stays offered.
  `BSC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // An error result carries zero fields.
  `BSC_ASSERT_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error data")

  // Input readiness follows the output register occupancy.
  `BSC_ASSERT_IMP(a_ready, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready")

endmodule

bind barometric_sensor_compensation_core bsc_checker u_bsc_checker (.*);
`default_nettype wire
